// ===== design/bbp_pkg.sv =====
// Shared types and constants for the bimodal branch predictor.
package bbp_pkg;

	localparam int ADDR_W  = 32;
	localparam int COUNT_W = 32;
	localparam int CFG_W   = 4;
	localparam int CTR_W   = 2;

	localparam logic [CFG_W-1:0] INDEX_BITS_RESET = 4'd12;

	// Two-bit saturating counter codes.
	localparam logic [CTR_W-1:0] CTR_STRONG_NT = 2'd0;
	localparam logic [CTR_W-1:0] CTR_WEAK_NT   = 2'd1;
	localparam logic [CTR_W-1:0] CTR_WEAK_T    = 2'd2;
	localparam logic [CTR_W-1:0] CTR_STRONG_T  = 2'd3;

	typedef struct packed {
		logic [ADDR_W-1:0] branch_address;
		logic              branch_taken;
	} branch_t;

	typedef struct packed {
		logic               predicted_taken;
		logic               prediction_correct;
		logic [COUNT_W-1:0] correct_count;
		logic [COUNT_W-1:0] branch_count;
	} result_t;

	typedef struct packed {
		logic clear_en;
		logic lookup;
		logic update;
	} bbp_cmd_t;

	typedef struct packed {
		logic clear_last;
	} bbp_status_t;

endpackage

// ===== design/bbp_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module bbp_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/bbp_ctrl.sv =====
// Controller: clearing pass after reset, then lookup and update of one word at a time.
module bbp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  bbp_pkg::bbp_status_t status,
	output bbp_pkg::bbp_cmd_t   cmd,
	output logic                busy
);
	import bbp_pkg::*;

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_UPDATE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (status.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign cmd.clear_en = (state_q == ST_CLEAR);
	assign cmd.lookup   = (state_q == ST_IDLE) && start;
	assign cmd.update   = (state_q == ST_UPDATE);

`ifndef ASSERT_OFF
	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.lookup |=> (busy && cmd.update))
		else $error("accepted word did not move to update");
	a_clear_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.clear_en && status.clear_last) |=> !busy)
		else $error("clearing pass did not end in idle");
`endif

endmodule

// ===== design/bbp_datapath.sv =====
// Datapath: index register, counter and valid RAMs, counter update and running totals.
module bbp_datapath #(
	parameter int INDEX_BITS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bbp_pkg::bbp_cmd_t         cmd,
	output bbp_pkg::bbp_status_t      status,
	input  logic                      cfg_we,
	input  logic [bbp_pkg::CFG_W-1:0] cfg_wdata,
	input  bbp_pkg::branch_t          branch,
	output bbp_pkg::result_t          result,
	output logic                      done
);
	import bbp_pkg::*;

	localparam int DEPTH = 2 ** INDEX_BITS;

	logic [CFG_W-1:0]      index_bits_q;
	logic [CFG_W-1:0]      eff_w;
	logic [INDEX_BITS-1:0] idx_mask;
	logic [INDEX_BITS-1:0] lookup_idx;
	logic [INDEX_BITS-1:0] idx_s1;
	logic                  taken_s1;
	logic [INDEX_BITS-1:0] clr_addr_q;

	logic                  valid_rd;
	logic [CTR_W-1:0]      ctr_rd;
	logic [CTR_W-1:0]      ctr_nxt;
	logic                  pred;
	logic                  correct;
	logic [COUNT_W-1:0]    correct_nxt;
	logic [COUNT_W-1:0]    branch_nxt;

	logic [COUNT_W-1:0]    correct_total_q;
	logic [COUNT_W-1:0]    branch_total_q;
	result_t               result_q;
	logic                  done_q;

	logic [INDEX_BITS-1:0] valid_waddr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q <= INDEX_BITS_RESET;
		end else if (cfg_we) begin
			index_bits_q <= cfg_wdata;
		end
	end

	// A width of zero counts as one; widths past the table size keep every index bit.
	assign eff_w = (index_bits_q == '0) ? CFG_W'(1) : index_bits_q;

	always_comb begin
		for (int i = 0; i < INDEX_BITS; i++) begin
			idx_mask[i] = (i < int'(eff_w));
		end
	end

	assign lookup_idx = branch.branch_address[INDEX_BITS-1:0] & idx_mask;

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			idx_s1   <= lookup_idx;
			taken_s1 <= branch.branch_taken;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear_en) begin
			clr_addr_q <= clr_addr_q + INDEX_BITS'(1);
		end
	end

	assign status.clear_last = (clr_addr_q == '1);
	assign valid_waddr       = cmd.clear_en ? clr_addr_q : idx_s1;

	bbp_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_valid_ram (
		.clk  (clk),
		.we   (cmd.clear_en || cmd.update),
		.waddr(valid_waddr),
		.wdata(!cmd.clear_en),
		.re   (cmd.lookup),
		.raddr(lookup_idx),
		.rdata(valid_rd)
	);

	bbp_ram #(
		.WIDTH(CTR_W),
		.DEPTH(DEPTH)
	) u_ctr_ram (
		.clk  (clk),
		.we   (cmd.update),
		.waddr(idx_s1),
		.wdata(ctr_nxt),
		.re   (cmd.lookup),
		.raddr(lookup_idx),
		.rdata(ctr_rd)
	);

	// A fresh entry predicts taken and starts weak in the direction of the outcome.
	always_comb begin
		if (!valid_rd) begin
			pred    = 1'b1;
			ctr_nxt = taken_s1 ? CTR_WEAK_T : CTR_WEAK_NT;
		end else begin
			pred = (ctr_rd == CTR_WEAK_T) || (ctr_rd == CTR_STRONG_T);
			if (taken_s1) begin
				ctr_nxt = (ctr_rd == CTR_STRONG_T) ? ctr_rd : ctr_rd + CTR_W'(1);
			end else begin
				ctr_nxt = (ctr_rd == CTR_STRONG_NT) ? ctr_rd : ctr_rd - CTR_W'(1);
			end
		end
	end

	assign correct     = (pred == taken_s1);
	assign branch_nxt  = (branch_total_q == '1) ? branch_total_q
	                                            : branch_total_q + COUNT_W'(1);
	assign correct_nxt = (!correct || correct_total_q == '1) ? correct_total_q
	                                                         : correct_total_q + COUNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			correct_total_q <= '0;
			branch_total_q  <= '0;
			done_q          <= 1'b0;
		end else begin
			done_q <= cmd.update;
			if (cmd.update) begin
				correct_total_q <= correct_nxt;
				branch_total_q  <= branch_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			result_q.predicted_taken    <= pred;
			result_q.prediction_correct <= correct;
			result_q.correct_count      <= correct_nxt;
			result_q.branch_count       <= branch_nxt;
		end
	end

	assign result = result_q;
	assign done   = done_q;

`ifndef ASSERT_OFF
	a_correct_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		correct_total_q <= branch_total_q)
		else $error("correct count exceeds branch count");
	a_done_counts: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (result_q.branch_count == branch_total_q && branch_total_q != '0))
		else $error("result word does not match running total");
`endif

endmodule

// ===== design/bimodal_branch_predictor_core.sv =====
// Done and the result word rise at the edge after the accepting edge.
// Busy holds off a new word until the last one has read then written the counter and valid RAMs.
// The receiver cannot stall; done is high for exactly one cycle, and the result port holds
// each word until the next update. Reset: counts clear, index_bits returns to 12, and busy
// stays high for a clearing pass over the whole valid RAM; config writes are taken throughout.
module bimodal_branch_predictor_core #(
	parameter int INDEX_BITS = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  bbp_pkg::branch_t          branch,
	output logic                      done,
	output bbp_pkg::result_t          result,
	input  logic                      cfg_we,
	input  logic [bbp_pkg::CFG_W-1:0] cfg_wdata
);
	import bbp_pkg::*;

	bbp_cmd_t    cmd;
	bbp_status_t status;

	bbp_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.status(status),
		.cmd   (cmd),
		.busy  (busy)
	);

	bbp_datapath #(
		.INDEX_BITS(INDEX_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.branch   (branch),
		.result   (result),
		.done     (done)
	);

`ifndef ASSERT_OFF
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result word without a preceding busy cycle");
`endif

endmodule

// ===== sim/bbp_checker.sv =====
// Checker that predicts every result word of the branch predictor and compares it on done.
module bbp_checker
	import bbp_pkg::*;
#(
	parameter int INDEX_BITS = 12
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  branch_t          branch,
	input  logic             done,
	input  result_t          result,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	output int               mismatches,
	output int               outstanding,
	output int               results_seen
);

	localparam int DEPTH = 1 << INDEX_BITS;

	logic [CTR_W-1:0]   ctr_shadow [DEPTH];
	logic               valid_shadow [DEPTH];
	logic [COUNT_W-1:0] correct_shadow;
	logic [COUNT_W-1:0] branches_shadow;
	logic [CFG_W-1:0]   width_shadow;
	result_t            expected_results [$];
	int                 err_count;
	int                 seen_count;

	// Index widths below one or above the table size are clamped.
	function automatic int unsigned table_index(logic [ADDR_W-1:0] addr);
		int unsigned w;
		w = width_shadow;
		if (w < 1)
			w = 1;
		if (w > INDEX_BITS)
			w = INDEX_BITS;
		return int'(addr & ((ADDR_W'(1) << w) - ADDR_W'(1)));
	endfunction

	function automatic result_t predict_branch(branch_t b);
		int unsigned      idx;
		logic [CTR_W-1:0] c;
		result_t          r;
		idx = table_index(b.branch_address);
		if (!valid_shadow[idx]) begin
			// First use of an entry always predicts taken and seeds a weak counter.
			r.predicted_taken = 1'b1;
			ctr_shadow[idx] = b.branch_taken ? CTR_WEAK_T : CTR_WEAK_NT;
			valid_shadow[idx] = 1'b1;
		end else begin
			c = ctr_shadow[idx];
			r.predicted_taken = (c == CTR_WEAK_T) || (c == CTR_STRONG_T);
			if (b.branch_taken && c != CTR_STRONG_T)
				c = c + CTR_W'(1);
			else if (!b.branch_taken && c != CTR_STRONG_NT)
				c = c - CTR_W'(1);
			ctr_shadow[idx] = c;
		end
		r.prediction_correct = (r.predicted_taken == b.branch_taken);
		if (r.prediction_correct && correct_shadow != '1)
			correct_shadow = correct_shadow + COUNT_W'(1);
		if (branches_shadow != '1)
			branches_shadow = branches_shadow + COUNT_W'(1);
		r.correct_count = correct_shadow;
		r.branch_count = branches_shadow;
		return r;
	endfunction

	function automatic void report(string field, logic [COUNT_W-1:0] want,
			logic [COUNT_W-1:0] got);
		if (err_count < 20)
			$display("%0t: %s expected %0h got %0h", $time, field, want, got);
		err_count++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				valid_shadow[i] = 1'b0;
			correct_shadow = '0;
			branches_shadow = '0;
			width_shadow = INDEX_BITS_RESET;
			expected_results.delete();
			err_count = 0;
			seen_count = 0;
		end else begin
			// A result word can never belong to a word accepted at the same edge,
			// so results are matched before the new word is predicted.
			if (done) begin
				seen_count++;
				if (expected_results.size() == 0) begin
					if (err_count < 20)
						$display("%0t: result word with none expected, got %p", $time, result);
					err_count++;
				end else begin
					want = expected_results.pop_front();
					if (result.predicted_taken !== want.predicted_taken)
						report("predicted_taken", want.predicted_taken, result.predicted_taken);
					if (result.prediction_correct !== want.prediction_correct)
						report("prediction_correct", want.prediction_correct,
							result.prediction_correct);
					if (result.correct_count !== want.correct_count)
						report("correct_count", want.correct_count, result.correct_count);
					if (result.branch_count !== want.branch_count)
						report("branch_count", want.branch_count, result.branch_count);
				end
			end
			// A word accepted at the edge of a width write still indexes with the old width.
			if (start && !busy)
				expected_results.push_back(predict_branch(branch));
			if (cfg_we)
				width_shadow = cfg_wdata;
		end
		mismatches <= err_count;
		outstanding <= expected_results.size();
		results_seen <= seen_count;
	end

endmodule

// ===== sim/tb_top.sv =====
// Top of the branch predictor testbench: clock, reset, branch stimulus and verdict.
module tb_top;
	import bbp_pkg::*;

	localparam int TBL_BITS = 12;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 215;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	branch_t          branch = '0;
	logic             done;
	result_t          result;
	logic             cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	int               mismatches;
	int               outstanding;
	int               results_seen;

	logic [ADDR_W-1:0] hot_addr [16];
	int                hot_bias [16];
	bit                calm = 1'b0;
	int                sent = 0;
	int                widths_used = 0;
	logic [CFG_W-1:0]  phase_width [PHASES - 1] = '{4'd1, 4'd0, 4'd15, 4'd13, 4'd4, 4'd12, 4'd7};

	bimodal_branch_predictor_core #(
		.INDEX_BITS(TBL_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.branch   (branch),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	bbp_checker #(
		.INDEX_BITS(TBL_BITS)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.branch      (branch),
		.done        (done),
		.result      (result),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.results_seen(results_seen)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("tb_top failed");
		$finish;
	end

	// Presents one word and returns at the edge that accepts it; start stays high.
	task automatic issue(branch_t b);
		if (!calm && $urandom_range(99) < 28) begin
			start <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		start <= 1'b1;
		branch <= b;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Written only with the block idle, after the last result word has come back.
	task automatic write_width(logic [CFG_W-1:0] w);
		drain();
		repeat (3) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_we <= 1'b0;
		widths_used++;
	endtask

	// Most branches come from a small set of hot sites so that counters move through
	// all four states; each site has its own taken bias and random upper address bits.
	function automatic branch_t random_branch();
		branch_t b;
		int      k;
		if ($urandom_range(99) < 75) begin
			k = $urandom_range(15);
			b.branch_address = ($urandom() & ~ADDR_W'(32'hFFF)) | (hot_addr[k] & ADDR_W'(32'hFFF));
			b.branch_taken = ($urandom_range(99) < hot_bias[k]);
		end else begin
			b.branch_address = $urandom();
			b.branch_taken = $urandom_range(1);
		end
		return b;
	endfunction

	initial begin
		logic [CFG_W-1:0] w;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset width: first use both ways, saturation at both ends, aliasing addresses.
		issue({32'h0000_0000, 1'b1});
		issue({32'h0000_0000, 1'b1});
		issue({32'h0000_0000, 1'b1});
		issue({32'h0000_0000, 1'b1});
		issue({32'h0000_0000, 1'b0});
		issue({32'h0000_0000, 1'b0});
		issue({32'h0000_0000, 1'b0});
		issue({32'h0000_0000, 1'b0});
		issue({32'hFFFF_FFFF, 1'b0});
		issue({32'hFFFF_FFFF, 1'b1});
		issue({32'hFFFF_F000, 1'b1});
		issue({32'h8000_0FFF, 1'b0});
		issue({32'h5555_5555, 1'b1});
		issue({32'hAAAA_AAAA, 1'b0});

		// A zero width behaves as one bit; the table contents survive the change.
		write_width(4'd0);
		issue({32'h0000_0002, 1'b1});
		issue({32'h0000_0003, 1'b0});
		issue({32'hFFFF_FFFF, 1'b1});

		// Widths past the table size are clamped to the full index.
		write_width(4'd15);
		issue({32'h0000_1FFF, 1'b1});
		issue({32'h0000_0ABC, 1'b1});
		issue({32'h1234_5ABC, 1'b0});

		for (int p = 0; p < PHASES; p++) begin
			w = (p == PHASES - 1) ? CFG_W'($urandom_range(15)) : phase_width[p];
			write_width(w);
			for (int k = 0; k < 16; k++) begin
				hot_addr[k] = $urandom();
				case ($urandom_range(3))
					0: hot_bias[k] = 5;
					1: hot_bias[k] = 30;
					2: hot_bias[k] = 70;
					default: hot_bias[k] = 95;
				endcase
			end
			calm = (p == 3);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (!calm && $urandom_range(49) == 0)
					drain();
				issue(random_branch());
			end
			calm = 1'b0;
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Ran %0d branches under %0d index width settings, zero and oversized included;",
			sent, widths_used);
		$display("%0d result words came back and were checked field by field.", results_seen);
		if (mismatches == 0 && outstanding == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
design/bbp_pkg.sv
design/bbp_ram.sv
design/bbp_ctrl.sv
design/bbp_datapath.sv
design/bimodal_branch_predictor_core.sv
sim/bbp_checker.sv
sim/tb_top.sv
